// ===== rtl/cji_pkg.sv =====
// ----------------------------------------------------------------------------
// cji_pkg
// Shared types and constants of the cubic joint interpolator.
// ----------------------------------------------------------------------------
package cji_pkg;

    localparam int QBITS = 31;  // quotient s in Q1.30, 0..2^30

    localparam logic [1:0] MODE_CUBIC  = 2'd0;
    localparam logic [1:0] MODE_BEFORE = 2'd1;
    localparam logic [1:0] MODE_AFTER  = 2'd2;

    localparam logic REG_START_TIME    = 1'b0;
    localparam logic REG_MOVE_DURATION = 1'b1;

    typedef struct packed {
        logic        [31:0] now_time;
        logic signed [31:0] start_position;
        logic signed [31:0] start_velocity;
        logic signed [31:0] goal_position;
    } cji_in_t;

    typedef struct packed {
        logic signed [31:0] joint_position;
        logic               saturated;
    } cji_out_t;

    // payload handed from cell to cell
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] q0;
        logic signed [31:0] v0;
        logic signed [31:0] qg;
        logic [31:0]        tau;
        logic [32:0]        rem;
        logic [QBITS-1:0]   quo;
    } cji_cell_t;

endpackage

// ===== rtl/cji_div_cell.sv =====
// ----------------------------------------------------------------------------
// cji_div_cell
// One restoring-division step: produces one quotient bit of tau*2^30/dur.
// ----------------------------------------------------------------------------
module cji_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic [31:0]         dur,
    input  logic                valid_in,
    input  cji_pkg::cji_cell_t  cell_in,
    output logic                valid_out,
    output cji_pkg::cji_cell_t  cell_out
);
    import cji_pkg::*;

    logic               valid_reg;
    cji_cell_t          cell_reg;
    cji_cell_t          cell_next;
    logic [32:0]        diff;
    logic               take;
    logic [32:0]        r;

    always_comb
    begin
        diff      = cell_in.rem - {1'b0, dur};
        take      = (cell_in.rem >= {1'b0, dur});
        r         = take ? diff : cell_in.rem;
        cell_next = cell_in;
        cell_next.rem = {r[31:0], 1'b0};   // r < dur, so doubling fits
        cell_next.quo = {cell_in.quo[QBITS-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cell_reg <= cell_next;
        end
    end

    assign valid_out = valid_reg;
    assign cell_out  = cell_reg;

endmodule

// ===== rtl/cji_poly.sv =====
// ----------------------------------------------------------------------------
// cji_poly
// Cubic blend, velocity term, sum, clamp and before/after select; ends in the output register.
// ----------------------------------------------------------------------------
module cji_poly (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                valid_in,
    input  cji_pkg::cji_cell_t  cell_in,
    output logic                out_valid,
    output cji_pkg::cji_out_t   out_data
);
    import cji_pkg::*;

    // stage 1: s*s, v0*tau, goal-start
    logic               p1_valid_reg;
    logic [1:0]         p1_mode_reg;
    logic signed [31:0] p1_q0_reg;
    logic signed [31:0] p1_qg_reg;
    logic [30:0]        p1_s_reg;
    logic [61:0]        p1_ssq_reg;
    logic signed [63:0] p1_vel_reg;
    logic signed [32:0] p1_diff_reg;

    logic signed [32:0] tau_s;
    logic signed [64:0] vel_full;
    logic signed [32:0] diff_next;

    assign tau_s     = $signed({1'b0, cell_in.tau});
    assign vel_full  = 65'(cell_in.v0) * 65'(tau_s);
    assign diff_next = 33'(cell_in.qg) - 33'(cell_in.q0);

    // stage 2: s2*(3-2s), velocity term shifted
    logic               p2_valid_reg;
    logic [1:0]         p2_mode_reg;
    logic signed [31:0] p2_q0_reg;
    logic signed [31:0] p2_qg_reg;
    logic [62:0]        p2_hprod_reg;
    logic signed [47:0] p2_velt_reg;
    logic signed [32:0] p2_diff_reg;

    logic [30:0]        s2;
    logic [31:0]        k;
    logic signed [63:0] vel_b;
    logic signed [63:0] vel_sh;

    assign s2     = p1_ssq_reg[60:30];
    assign k      = 32'hC000_0000 - {p1_s_reg, 1'b0};
    assign vel_b  = p1_vel_reg + (p1_vel_reg[63] ? 64'sh0000_FFFF : 64'sh0);
    assign vel_sh = vel_b >>> 16;

    // stage 3: (goal-start)*h
    logic               p3_valid_reg;
    logic [1:0]         p3_mode_reg;
    logic signed [31:0] p3_q0_reg;
    logic signed [31:0] p3_qg_reg;
    logic signed [47:0] p3_velt_reg;
    logic signed [63:0] p3_bprod_reg;

    logic [30:0]        h;
    assign h = p2_hprod_reg[60:30];

    // stage 4: sum, clamp, select
    logic               out_valid_reg;
    cji_out_t           out_data_reg;
    cji_out_t           out_next;
    logic signed [63:0] b_bias;
    logic signed [63:0] b_sh;
    logic signed [49:0] sum;

    always_comb
    begin
        b_bias = p3_bprod_reg + (p3_bprod_reg[63] ? 64'sh3FFF_FFFF : 64'sh0);
        b_sh   = b_bias >>> 30;
        sum    = 50'(p3_q0_reg) + 50'(p3_velt_reg) + 50'($signed(b_sh[33:0]));
        out_next.saturated = 1'b0;
        if (sum > 50'sh7FFF_FFFF)
        begin
            out_next.joint_position = 32'sh7FFF_FFFF;
            out_next.saturated      = 1'b1;
        end
        else if (sum < -50'sh8000_0000)
        begin
            out_next.joint_position = 32'sh8000_0000;
            out_next.saturated      = 1'b1;
        end
        else
        begin
            out_next.joint_position = sum[31:0];
        end
        case (p3_mode_reg)
            MODE_BEFORE:
            begin
                out_next.joint_position = p3_q0_reg;
                out_next.saturated      = 1'b0;
            end
            MODE_AFTER:
            begin
                out_next.joint_position = p3_qg_reg;
                out_next.saturated      = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg  <= valid_in;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_mode_reg  <= cell_in.mode;
            p1_q0_reg    <= cell_in.q0;
            p1_qg_reg    <= cell_in.qg;
            p1_s_reg     <= cell_in.quo;
            p1_ssq_reg   <= 62'(cell_in.quo) * 62'(cell_in.quo);
            p1_vel_reg   <= vel_full[63:0];
            p1_diff_reg  <= diff_next;

            p2_mode_reg  <= p1_mode_reg;
            p2_q0_reg    <= p1_q0_reg;
            p2_qg_reg    <= p1_qg_reg;
            p2_hprod_reg <= 63'(s2) * 63'(k);
            p2_velt_reg  <= vel_sh[47:0];
            p2_diff_reg  <= p1_diff_reg;

            p3_mode_reg  <= p2_mode_reg;
            p3_q0_reg    <= p2_q0_reg;
            p3_qg_reg    <= p2_qg_reg;
            p3_velt_reg  <= p2_velt_reg;
            p3_bprod_reg <= 64'(p2_diff_reg) * 64'($signed({1'b0, h}));

            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/cubic_joint_interpolator.sv =====
// ----------------------------------------------------------------------------
// cubic_joint_interpolator
// Cubic joint trajectory interpolator, one joint sample per item.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  in      | in_valid/in_ready   | in_data  (now, start pos/vel, goal)
//  out     | out_valid/out_ready | out_data (joint_position, saturated)
//  cfg     | cfg_we              | cfg_index, cfg_data
//
//  One item per cycle sustained while the output is taken. The pipe is an entry
//  register, 31 division cells (one quotient bit of s each), three multiply stages
//  and the output register. The whole pipe moves when the output register is
//  empty or being taken; in_ready follows that. Reset clears all valid bits
//  and loads start_time = 0, move_duration = 1.0 s.
// ----------------------------------------------------------------------------
module cubic_joint_interpolator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cji_pkg::cji_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cji_pkg::cji_out_t  out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    import cji_pkg::*;

    // configuration
    logic [31:0] start_time_reg;
    logic [31:0] move_duration_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg    <= 32'd0;
            move_duration_reg <= 32'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_TIME:    start_time_reg    <= cfg_data;
                REG_MOVE_DURATION: move_duration_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // zero duration behaves as one LSB
    logic [31:0] dur;
    assign dur = (move_duration_reg == 32'd0) ? 32'd1 : move_duration_reg;

    // global advance: whole pipe shifts when the output slot frees up
    logic adv;
    logic poly_out_valid;
    assign adv      = !poly_out_valid || out_ready;
    assign in_ready = adv;

    // entry stage: classify time, form tau, seed the divider
    logic [32:0] end_time;
    cji_cell_t   seed;
    assign end_time = {1'b0, start_time_reg} + {1'b0, dur};

    always_comb
    begin
        seed.q0  = in_data.start_position;
        seed.v0  = in_data.start_velocity;
        seed.qg  = in_data.goal_position;
        seed.tau = in_data.now_time - start_time_reg;
        seed.rem = {1'b0, seed.tau};
        seed.quo = '0;
        if (in_data.now_time < start_time_reg)
        begin
            seed.mode = MODE_BEFORE;
        end
        else if ({1'b0, in_data.now_time} > end_time)
        begin
            seed.mode = MODE_AFTER;
        end
        else
        begin
            seed.mode = MODE_CUBIC;
        end
    end

    logic      entry_valid_reg;
    cji_cell_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            entry_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            entry_reg <= seed;
        end
    end

    // chain of division cells; s = floor(tau*2^30/dur) emerges MSB first
    logic      chain_valid [0:QBITS];
    cji_cell_t chain_cell  [0:QBITS];

    assign chain_valid[0] = entry_valid_reg;
    assign chain_cell[0]  = entry_reg;

    genvar gi;
    generate
        for (gi = 0; gi < QBITS; gi++)
        begin : g_cell
            cji_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .dur       (dur),
                .valid_in  (chain_valid[gi]),
                .cell_in   (chain_cell[gi]),
                .valid_out (chain_valid[gi+1]),
                .cell_out  (chain_cell[gi+1])
            );
        end
    endgenerate

    // polynomial back end with output register
    cji_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (chain_valid[QBITS]),
        .cell_in   (chain_cell[QBITS]),
        .out_valid (poly_out_valid),
        .out_data  (out_data)
    );

    assign out_valid = poly_out_valid;

endmodule

// ===== verif/cubic_joint_interpolator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_joint_interpolator_tb
// Self-checking bench for the cubic joint interpolator. Items are queued by
// the sequence, sent in random bursts, and every result is compared with an
// in-bench model of the cubic blend, clamp and before/after cases. The
// receiver stalls on a rotating pattern and once holds off long enough to
// back the pipe up into the input.
// ----------------------------------------------------------------------------
module cubic_joint_interpolator_tb;
    import cji_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_DRAIN  = 50;     // wait for the pipe to empty, with margin

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    cji_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    cji_out_t    out_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    // mirror of the block's registers, changed only while the pipe is empty
    logic [31:0] mir_start = 32'd0;
    logic [31:0] mir_dur   = 32'd65536;

    cji_in_t  item_queue[$];     // items waiting to be sent
    cji_out_t position_queue[$]; // predicted results, oldest first

    int unsigned cyc = 0;
    int unsigned items_queued = 0;
    int unsigned items_checked = 0;
    int unsigned sat_seen = 0;
    int unsigned fail_count = 0;
    int unsigned cfg_settings = 1;

    cubic_joint_interpolator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint trunc_shift(longint v, int n);
        if (v >= 0)
            return v >>> n;
        return -((-v) >>> n);
    endfunction

    function automatic cji_out_t predict_position(cji_in_t it);
        cji_out_t    r;
        logic [63:0] dur;
        logic [63:0] t_end;
        logic [63:0] tau;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] h;
        longint      q0;
        longint      v0;
        longint      qg;
        longint      sum;
        dur   = (mir_dur == 32'd0) ? 64'd1 : {32'd0, mir_dur};
        t_end = {32'd0, mir_start} + dur;
        q0    = it.start_position;
        v0    = it.start_velocity;
        qg    = it.goal_position;
        r.saturated = 1'b0;
        if ({32'd0, it.now_time} < {32'd0, mir_start}) begin
            r.joint_position = it.start_position;
        end else if ({32'd0, it.now_time} > t_end) begin
            r.joint_position = it.goal_position;
        end else begin
            tau = {32'd0, it.now_time} - {32'd0, mir_start};
            s   = (tau << 30) / dur;
            s2  = (s * s) >> 30;
            h   = (s2 * ((64'd3 << 30) - 2 * s)) >> 30;
            sum = q0 + trunc_shift(v0 * longint'(tau), 16)
                + trunc_shift((qg - q0) * longint'(h), 30);
            if (sum > 64'sd2147483647) begin
                sum = 64'sd2147483647;
                r.saturated = 1'b1;
            end else if (sum < -64'sd2147483648) begin
                sum = -64'sd2147483648;
                r.saturated = 1'b1;
            end
            r.joint_position = sum[31:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    int unsigned burst_left = 8;
    int unsigned gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                position_queue.push_back(predict_position(in_data));
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (item_queue.size() > 0) begin
                    in_data  <= item_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        // a quarter of bursts run back to back
                        burst_left <= ($urandom_range(0, 9) == 0) ?
                                      $urandom_range(50, 200) : $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 :
                                      $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: rotating stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (!hold_done && item_queue.size() > 60) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= (hold_left == 1);
            end else begin
                case ((cyc / 300) % 4)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    2:       out_ready <= (cyc % 5) != 0;
                    default: out_ready <= $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    // monitor: compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        cji_out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (position_queue.size() == 0) begin
                $error("result with nothing expected: pos=%0d sat=%0b",
                       out_data.joint_position, out_data.saturated);
                fail_count++;
            end else begin
                want = position_queue.pop_front();
                if (out_data.joint_position !== want.joint_position) begin
                    $error("joint_position: expected %0d, got %0d",
                           want.joint_position, out_data.joint_position);
                    fail_count++;
                end
                if (out_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, out_data.saturated);
                    fail_count++;
                end
                if (want.saturated)
                    sat_seen++;
            end
            items_checked++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding",
                     items_queued - items_checked);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_START_TIME)
            mir_start = val;
        else
            mir_dur = val;
    endtask

    task automatic set_move(logic [31:0] t0, logic [31:0] dur);
        write_reg(REG_START_TIME, t0);
        write_reg(REG_MOVE_DURATION, dur);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    task automatic queue_item(logic [31:0] now, logic [31:0] q0, logic [31:0] v0,
                              logic [31:0] qg);
        cji_in_t it;
        it.now_time       = now;
        it.start_position = q0;
        it.start_velocity = v0;
        it.goal_position  = qg;
        item_queue.push_back(it);
        items_queued++;
    endtask

    // wait for every queued item to come back, then let the pipe empty
    task automatic drain_pipe();
        while (items_checked != items_queued)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return $urandom_range(0, 262144) - 131072;
            2:       return $urandom_range(0, 1 << 26) - (1 << 25);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_now();
        logic [32:0] dur;
        logic [32:0] t_end;
        logic [32:0] t;
        dur   = (mir_dur == 0) ? 33'd1 : {1'b0, mir_dur};
        t_end = {1'b0, mir_start} + dur;
        case ($urandom_range(0, 11))
            0:  return $urandom;
            1:  return (mir_start > 0) ? $urandom_range(0, mir_start - 1) : $urandom;
            2:  return (t_end < 33'hFFFF_FFFF) ?
                       $urandom_range(t_end[31:0] + 1, 32'hFFFF_FFFF) : $urandom;
            3:  return mir_start;
            4:  return t_end[32] ? $urandom : t_end[31:0];
            default:
            begin
                t = {1'b0, mir_start} + $urandom_range(0, dur[31:0]);
                return t[32] ? $urandom : t[31:0];
            end
        endcase
    endfunction

    task automatic random_items(int n);
        repeat (n)
            queue_item(rand_now(), rand_pos(), rand_pos(), rand_pos());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: start 0, one second
        queue_item(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        queue_item(32'd32768, 32'h0001_0000, 32'd0, 32'h0005_0000);
        queue_item(32'd65536, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_item(32'd65537, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        // overflow upward and downward
        queue_item(32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_item(32'd65536, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_item(32'd49152, 32'h7000_0000, 32'h4000_0000, 32'h7FFF_FFFF);
        random_items(220);
        drain_pipe();

        // before start, and the two boundaries
        set_move(32'h0001_0000, 32'h0002_0000);
        queue_item(32'h0000_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_item(32'h0001_0000, 32'h0010_0000, 32'h8000_0000, 32'hFFF0_0000);
        queue_item(32'h0003_0000, 32'h0010_0000, 32'h8000_0000, 32'hFFF0_0000);
        queue_item(32'h0003_0001, 32'h0010_0000, 32'h8000_0000, 32'hFFF0_0000);
        random_items(220);
        drain_pipe();

        // zero duration is taken as one unit
        set_move(32'd100, 32'd0);
        queue_item(32'd99, 32'h0000_1000, 32'h7FFF_FFFF, 32'h0000_2000);
        queue_item(32'd100, 32'h0000_1000, 32'h7FFF_FFFF, 32'h0000_2000);
        queue_item(32'd101, 32'h0000_1000, 32'h7FFF_FFFF, 32'h0000_2000);
        queue_item(32'd102, 32'h0000_1000, 32'h7FFF_FFFF, 32'h0000_2000);
        random_items(150);
        drain_pipe();

        // largest values of both registers
        set_move(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_item(32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_items(100);
        drain_pipe();

        // long move from zero: tau spans the full 32 bits
        set_move(32'd0, 32'hFFFF_FFFF);
        queue_item(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_item(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        random_items(150);
        drain_pipe();

        set_move(32'd0, 32'd1);
        random_items(100);
        drain_pipe();

        repeat (3)
        begin
            set_move($urandom, $urandom_range(1, 32'h0010_0000));
            random_items(130);
            drain_pipe();
        end

        $display("%0d items checked over %0d register settings, %0d saturated",
                 items_checked, cfg_settings, sat_seen);
        $display("receiver hold-off %0s, %0d failures",
                 hold_done ? "done" : "not reached", fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== cubic_joint_interpolator.f =====
rtl/cji_pkg.sv
rtl/cji_div_cell.sv
rtl/cji_poly.sv
rtl/cubic_joint_interpolator.sv
verif/cubic_joint_interpolator_tb.sv
